### sv/lru_set_assoc_cache_sim_macros.svh
// Assertion helpers for the checker module of this block.
// Each expects signals named clk and rst in the scope where it is used.
`ifndef LRU_SET_ASSOC_CACHE_SIM_MACROS_SVH
`define LRU_SET_ASSOC_CACHE_SIM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/lsac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsac_pkg;

  // Field widths of the stream payloads.
  localparam int ACTION_W    = 2;
  localparam int ADDR_W      = 32;
  localparam int TOTAL_W     = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 104;

  // Bit positions of the result fields in the master tdata.
  localparam int OUT_OUTCOME_LSB = 0;
  localparam int OUT_SECOND_LSB  = 2;
  localparam int OUT_HITS_LSB    = 3;
  localparam int OUT_MISSES_LSB  = 35;
  localparam int OUT_EVICTS_LSB  = 67;
  localparam int OUT_PAD_W       = 5;

  // Configuration port.
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 5;
  localparam int SET_BITS_W     = 3;
  localparam int WAYS_USED_W    = 4;
  localparam int BLOCK_BITS_W   = 5;
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd2;
  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
  localparam logic [WAYS_USED_W-1:0]  WAYS_USED_RST  = 4'd1;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_STORE  = 2'd1,
    ACT_MODIFY = 2'd2,
    ACT_INSTR  = 2'd3
  } action_t;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_MISS  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;
  localparam logic [1:0] OUT_NONE  = 2'd3;

  // One cache line as kept in the line memory.
  typedef struct packed {
    logic                valid;
    logic [ADDR_W-1:0]   tag;
    logic [TOTAL_W-1:0]  stamp;
  } line_t;

  // Sequencer to way scanner.
  typedef struct packed {
    logic init;
    logic eval;
  } scan_ctrl_t;

  // Way scanner to sequencer.
  typedef struct packed {
    logic hit;
    logic free;
  } scan_flags_t;

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
    sat_inc = (v == {TOTAL_W{1'b1}}) ? v : v + TOTAL_W'(1);
  endfunction

endpackage

`default_nettype wire

### sv/lsac_line_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module lsac_line_mem
  import lsac_pkg::*;
#(
  parameter int AW = 9
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire line_t         wdata,
  input  wire logic [AW-1:0] raddr,
  output line_t              rdata
);

  line_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/lsac_way_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module lsac_way_scan
  import lsac_pkg::*;
#(
  parameter int WAY_W = 3
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire scan_ctrl_t         ctrl,
  input  wire logic [WAY_W-1:0]   way,
  input  wire line_t              entry,
  input  wire logic [ADDR_W-1:0]  tag,
  input  wire logic [TOTAL_W-1:0] now,
  output scan_flags_t             flags,
  output logic [WAY_W-1:0]        hit_way,
  output logic [WAY_W-1:0]        free_way,
  output logic [WAY_W-1:0]        old_way
);

  logic               seen;
  logic [TOTAL_W-1:0] best_age;
  logic [TOTAL_W-1:0] age;
  logic               match;

  assign match = entry.valid && (entry.tag == tag);
  assign age   = now - entry.stamp;

  // One way per cycle; the first match and first empty way win, and the
  // oldest stamp only moves on a strictly larger age so ties keep the lower way.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      seen  <= 1'b0;
    end else if (ctrl.init) begin
      flags <= '0;
      seen  <= 1'b0;
    end else if (ctrl.eval) begin
      seen <= 1'b1;
      if (match && !flags.hit) begin
        flags.hit <= 1'b1;
        hit_way   <= way;
      end
      if (!entry.valid && !flags.free) begin
        flags.free <= 1'b1;
        free_way   <= way;
      end
      if (!seen || (age > best_age)) begin
        best_age <= age;
        old_way  <= way;
      end
    end
  end

endmodule

`default_nettype wire

### sv/lru_set_assoc_cache_sim.sv
`timescale 1ns / 1ps
`default_nettype none

// Trace-driven hit/miss model of a set-associative LRU cache. Each request is
// one trace record; one result with the outcome and the saturating totals
// comes back for every record. After reset the block sweeps the line memory
// once to clear all 2**(MAX_SET_BITS + way index bits) lines (512 at the
// defaults), one line per cycle; no request is taken during the sweep, while
// configuration writes are. An access reads the ways of its set one per cycle
// from the line memory (one write port, one read port) through one shared tag
// compare and age compare. A new request is taken only back in idle: a load
// or store passes prep, scan over the ways in use, last, resolve and fin;
// a modify runs prep to resolve twice before fin; an instruction record goes
// from prep to fin. A result that is still waiting when the next record
// finishes holds that record until the waiting result is taken.
module lru_set_assoc_cache_sim
  import lsac_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [1:0] action, [33:2] address, [39:34] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [1:0] outcome, [2] second_hit, [34:3] hits_total, [66:35] misses_total,
  // [98:67] evictions_total, [103:99] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
  localparam int SB_W    = $clog2(MAX_SET_BITS + 1);
  localparam int SH_W    = $clog2(MAX_SET_BITS + 32);
  localparam int LINE_AW = MAX_SET_BITS + WAY_W;

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_PREP    = 7'b0000100,
    ST_SCAN    = 7'b0001000,
    ST_LAST    = 7'b0010000,
    ST_RESOLVE = 7'b0100000,
    ST_FIN     = 7'b1000000
  } state_t;

  state_t state;

  logic [SET_BITS_W-1:0]   cfg_set_bits;
  logic [WAYS_USED_W-1:0]  cfg_ways_used;
  logic [BLOCK_BITS_W-1:0] cfg_block_bits;

  logic [LINE_AW-1:0]      clr_addr;
  action_t                 act;
  logic [ADDR_W-1:0]       addr;
  logic [MAX_SET_BITS-1:0] set_idx;
  logic [ADDR_W-1:0]       tag;
  logic [WAY_W-1:0]        last_way;
  logic [WAY_W-1:0]        rd_way;
  logic                    second;
  logic [1:0]              outcome;
  logic                    second_hit;
  logic [TOTAL_W-1:0]      rec_time;
  logic [TOTAL_W-1:0]      hits;
  logic [TOTAL_W-1:0]      misses;
  logic [TOTAL_W-1:0]      evicts;
  logic                    eval_v;
  logic [WAY_W-1:0]        eval_way;

  logic [1:0]              out_outcome;
  logic                    out_second;
  logic [TOTAL_W-1:0]      out_hits;
  logic [TOTAL_W-1:0]      out_misses;
  logic [TOTAL_W-1:0]      out_evicts;

  // Set index, tag and way count of the current record.
  logic [SB_W-1:0]         sb_eff;
  logic [SH_W-1:0]         tag_shift;
  logic [ADDR_W-1:0]       set_shifted;
  logic [MAX_SET_BITS-1:0] set_next;
  logic [ADDR_W-1:0]       tag_next;
  logic [WCNT_W-1:0]       ways_eff;

  always_comb begin
    sb_eff = (32'(cfg_set_bits) > 32'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS)
                                                     : SB_W'(cfg_set_bits);
    tag_shift   = SH_W'(sb_eff) + SH_W'(cfg_block_bits);
    set_shifted = addr >> cfg_block_bits;
    set_next    = set_shifted[MAX_SET_BITS-1:0] & ~({MAX_SET_BITS{1'b1}} << sb_eff);
    tag_next    = (tag_shift >= SH_W'(32)) ? '0 : (addr >> tag_shift);
    if (cfg_ways_used == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (32'(cfg_ways_used) > 32'(MAX_WAYS)) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(cfg_ways_used);
    end
  end

  // Line memory and the shared way scanner.
  line_t              rd_line;
  line_t              wr_line;
  logic               mem_we;
  logic [LINE_AW-1:0] mem_waddr;
  scan_ctrl_t         scan_ctrl;
  scan_flags_t        scan_flags;
  logic [WAY_W-1:0]   hit_way;
  logic [WAY_W-1:0]   free_way;
  logic [WAY_W-1:0]   old_way;
  logic [WAY_W-1:0]   fill_way;

  always_comb begin
    priority if (scan_flags.hit) begin
      fill_way = hit_way;
    end else if (scan_flags.free) begin
      fill_way = free_way;
    end else begin
      fill_way = old_way;
    end
    mem_we = (state == ST_CLEAR) || (state == ST_RESOLVE);
    if (state == ST_CLEAR) begin
      mem_waddr = clr_addr;
      wr_line   = '0;
    end else begin
      mem_waddr     = {set_idx, fill_way};
      wr_line.valid = 1'b1;
      wr_line.tag   = tag;
      wr_line.stamp = rec_time;
    end
  end

  assign scan_ctrl.init = (state == ST_PREP);
  assign scan_ctrl.eval = eval_v;

  lsac_line_mem #(
    .AW (LINE_AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wr_line),
    .raddr ({set_idx, rd_way}),
    .rdata (rd_line)
  );

  lsac_way_scan #(
    .WAY_W (WAY_W)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (scan_ctrl),
    .way      (eval_way),
    .entry    (rd_line),
    .tag      (tag),
    .now      (rec_time),
    .flags    (scan_flags),
    .hit_way  (hit_way),
    .free_way (free_way),
    .old_way  (old_way)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_set_bits   <= SET_BITS_RST;
      cfg_ways_used  <= WAYS_USED_RST;
      cfg_block_bits <= BLOCK_BITS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SET_BITS:   cfg_set_bits   <= cfg_data[SET_BITS_W-1:0];
        REG_WAYS_USED:  cfg_ways_used  <= cfg_data[WAYS_USED_W-1:0];
        REG_BLOCK_BITS: cfg_block_bits <= cfg_data[BLOCK_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);

  // Read data comes back in the cycle after the address, so the way tag follows.
  always_ff @(posedge clk) begin
    if (rst) begin
      eval_v <= 1'b0;
    end else begin
      eval_v <= (state == ST_SCAN);
    end
    eval_way <= rd_way;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      second        <= 1'b0;
      rec_time      <= '0;
      hits          <= '0;
      misses        <= '0;
      evicts        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // ST_FIN sets the valid flag itself whenever the result is taken there.
      if (m_axis_tready && (state != ST_FIN)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + LINE_AW'(1);
          if (clr_addr == {LINE_AW{1'b1}}) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            act    <= action_t'(s_axis_tdata[ACTION_W-1:0]);
            addr   <= s_axis_tdata[ACTION_W +: ADDR_W];
            second <= 1'b0;
            state  <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (act == ACT_INSTR) begin
            outcome    <= OUT_NONE;
            second_hit <= 1'b0;
            state      <= ST_FIN;
          end else begin
            set_idx  <= set_next;
            tag      <= tag_next;
            last_way <= WAY_W'(ways_eff - WCNT_W'(1));
            rd_way   <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_way <= rd_way + WAY_W'(1);
          if (rd_way == last_way) begin
            state <= ST_LAST;
          end
        end
        ST_LAST: begin
          state <= ST_RESOLVE;
        end
        ST_RESOLVE: begin
          if (scan_flags.hit) begin
            hits <= sat_inc(hits);
          end else begin
            misses <= sat_inc(misses);
            if (!scan_flags.free) begin
              evicts <= sat_inc(evicts);
            end
          end
          if (!second) begin
            second_hit <= 1'b0;
            priority if (scan_flags.hit) begin
              outcome <= OUT_HIT;
            end else if (scan_flags.free) begin
              outcome <= OUT_MISS;
            end else begin
              outcome <= OUT_EVICT;
            end
          end else begin
            second_hit <= scan_flags.hit;
          end
          if ((act == ACT_MODIFY) && !second) begin
            second <= 1'b1;
            state  <= ST_PREP;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_outcome   <= outcome;
            out_second    <= second_hit;
            out_hits      <= hits;
            out_misses    <= misses;
            out_evicts    <= evicts;
            m_axis_tvalid <= 1'b1;
            rec_time      <= rec_time + TOTAL_W'(1);
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_evicts, out_misses, out_hits,
                         out_second, out_outcome};

endmodule

`default_nettype wire

### sv/lsac_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "lru_set_assoc_cache_sim_macros.svh"

module lsac_checker
  import lsac_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [1:0]         outcome;
  logic               second_hit;
  logic [TOTAL_W-1:0] hits_total;
  logic [TOTAL_W-1:0] misses_total;
  logic [TOTAL_W-1:0] evictions_total;

  assign outcome         = m_axis_tdata[OUT_OUTCOME_LSB +: 2];
  assign second_hit      = m_axis_tdata[OUT_SECOND_LSB];
  assign hits_total      = m_axis_tdata[OUT_HITS_LSB +: TOTAL_W];
  assign misses_total    = m_axis_tdata[OUT_MISSES_LSB +: TOTAL_W];
  assign evictions_total = m_axis_tdata[OUT_EVICTS_LSB +: TOTAL_W];

  // A stalled result keeps its contents.
  `LSAC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // After taking a request the block is still busy in the cycle after.
  `LSAC_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready,
    !s_axis_tready, "request taken on consecutive cycles")

  // A modify whose second access hit has counted at least one hit.
  `LSAC_ASSERT_NOW(a_second_hit, m_axis_tvalid && second_hit,
    (hits_total != '0) && (outcome != OUT_NONE), "second hit without a hit")

  // An eviction is always also a miss, and totals never wrap back to zero.
  `LSAC_ASSERT_NOW(a_evict_counts, m_axis_tvalid && (outcome == OUT_EVICT),
    (evictions_total != '0) && (misses_total != '0), "eviction not counted")

endmodule

bind lru_set_assoc_cache_sim lsac_checker u_lsac_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### bench/lru_set_assoc_cache_sim_tb.sv
`timescale 1ns / 1ps

module lru_set_assoc_cache_sim_tb;
  import lsac_pkg::*;

  localparam int SET_BITS_MAX = 6;
  localparam int WAYS_MAX     = 8;
  localparam int LINES        = (1 << SET_BITS_MAX) * WAYS_MAX;

  typedef struct packed {
    logic [1:0]         outcome;
    logic               second_hit;
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] misses;
    logic [TOTAL_W-1:0] evictions;
  } record_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  lru_set_assoc_cache_sim dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the cache state and its geometry registers.
  logic [SET_BITS_W-1:0]   geo_set_bits = SET_BITS_RST;
  logic [WAYS_USED_W-1:0]  geo_ways = WAYS_USED_RST;
  logic [BLOCK_BITS_W-1:0] geo_block_bits = BLOCK_BITS_RST;
  logic                    way_valid [LINES];
  logic [31:0]             way_tag [LINES];
  logic [31:0]             way_stamp [LINES];
  logic [31:0]             record_clock = '0;
  logic [TOTAL_W-1:0]      pred_hits = '0;
  logic [TOTAL_W-1:0]      pred_misses = '0;
  logic [TOTAL_W-1:0]      evict_count = '0;

  record_result_t expected_results [$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_hold_cycles = 0;

  function automatic int unsigned eff_set_bits();
    return (geo_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : int'(geo_set_bits);
  endfunction

  function automatic int unsigned eff_ways();
    if (geo_ways == 0) return 1;
    return (geo_ways > WAYS_MAX) ? WAYS_MAX : int'(geo_ways);
  endfunction

  // One lookup with LRU fill; returns the outcome code of the access.
  function automatic logic [1:0] cache_access(input logic [31:0] addr);
    int unsigned sb;
    int unsigned ways;
    int unsigned shift;
    logic [31:0] set_idx;
    logic [31:0] tag;
    logic [31:0] age;
    logic [31:0] best_age;
    int base;
    int victim;
    sb = eff_set_bits();
    ways = eff_ways();
    shift = sb + geo_block_bits;
    set_idx = (addr >> geo_block_bits) & ((32'd1 << sb) - 32'd1);
    tag = (shift >= 32) ? 32'd0 : (addr >> shift);
    base = int'(set_idx) * WAYS_MAX;
    for (int w = 0; w < ways; w++) begin
      if (way_valid[base + w] && way_tag[base + w] == tag) begin
        way_stamp[base + w] = record_clock;
        pred_hits = (pred_hits == '1) ? pred_hits : pred_hits + 1;
        return OUT_HIT;
      end
    end
    pred_misses = (pred_misses == '1) ? pred_misses : pred_misses + 1;
    for (int w = 0; w < ways; w++) begin
      if (!way_valid[base + w]) begin
        way_valid[base + w] = 1'b1;
        way_tag[base + w] = tag;
        way_stamp[base + w] = record_clock;
        return OUT_MISS;
      end
    end
    victim = 0;
    best_age = record_clock - way_stamp[base];
    for (int w = 1; w < ways; w++) begin
      age = record_clock - way_stamp[base + w];
      if (age > best_age) begin
        best_age = age;
        victim = w;
      end
    end
    way_tag[base + victim] = tag;
    way_stamp[base + victim] = record_clock;
    evict_count = (evict_count == '1) ? evict_count : evict_count + 1;
    return OUT_EVICT;
  endfunction

  function automatic record_result_t predict_record(input action_t act,
                                                    input logic [31:0] addr);
    record_result_t r;
    r.outcome = OUT_NONE;
    r.second_hit = 1'b0;
    if (act != ACT_INSTR) begin
      r.outcome = cache_access(addr);
      if (act == ACT_MODIFY) r.second_hit = (cache_access(addr) == OUT_HIT);
    end
    record_clock = record_clock + 1;
    r.hits = pred_hits;
    r.misses = pred_misses;
    r.evictions = evict_count;
    return r;
  endfunction

  // Builds an address that lands on the given tag and set under the current geometry.
  function automatic logic [31:0] make_addr(input logic [31:0] tag,
                                            input logic [31:0] set_idx);
    logic [63:0] a;
    int unsigned sb;
    int unsigned shift;
    sb = eff_set_bits();
    shift = sb + geo_block_bits;
    a = (64'(tag) << shift)
        | (64'(set_idx & ((32'd1 << sb) - 32'd1)) << geo_block_bits)
        | (64'($urandom) & ((64'd1 << geo_block_bits) - 64'd1));
    return a[31:0];
  endfunction

  task automatic send_record(input action_t act, input logic [31:0] addr);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, addr, act};
    do @(posedge clk); while (!s_axis_tready);
    expected_results.push_back(predict_record(act, addr));
  endtask

  task automatic wait_drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (expected_results.size() == 0);
    // Let the block settle back to idle before going on.
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    unique case (idx)
      REG_SET_BITS: geo_set_bits = SET_BITS_W'(value);
      REG_WAYS_USED: geo_ways = WAYS_USED_W'(value);
      REG_BLOCK_BITS: geo_block_bits = BLOCK_BITS_W'(value);
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned sb, input int unsigned ways,
                           input int unsigned bb);
    write_reg(REG_SET_BITS, sb);
    write_reg(REG_WAYS_USED, ways);
    write_reg(REG_BLOCK_BITS, bb);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly records that reuse a few sets and slightly more tags than ways, so
  // hits, fills and evictions all occur; the rest are random noise. The sender
  // stops halfway until every pending result has come back.
  task automatic run_trace(input int unsigned sb, input int unsigned ways,
                           input int unsigned bb, input int unsigned count);
    logic [31:0] tag_pool [10];
    logic [31:0] set_pool [3];
    int unsigned n_tags;
    int unsigned pick;
    action_t act;
    logic [31:0] addr;
    configure(sb, ways, bb);
    foreach (tag_pool[i]) tag_pool[i] = $urandom;
    foreach (set_pool[i]) set_pool[i] = $urandom;
    n_tags = eff_ways() + 2;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 85) begin
        pick = $urandom_range(9);
        act = (pick < 3) ? ACT_LOAD : (pick < 6) ? ACT_STORE :
              (pick < 9) ? ACT_MODIFY : ACT_INSTR;
        addr = make_addr(tag_pool[$urandom_range(n_tags - 1)], set_pool[$urandom_range(2)]);
      end else begin
        act = action_t'($urandom_range(3));
        addr = $urandom;
      end
      send_record(act, addr);
      if (i == count / 2) wait_drain();
    end
    wait_drain();
  endtask

  task automatic test_reset_geometry();
    send_record(ACT_LOAD, 32'h0000_0000);
    send_record(ACT_LOAD, 32'h0000_0000);
    send_record(ACT_STORE, 32'h0000_000F);
    send_record(ACT_STORE, 32'h0000_0010);
    send_record(ACT_MODIFY, 32'h0000_0100);
    send_record(ACT_LOAD, 32'h0000_0000);
    send_record(ACT_INSTR, 32'hFFFF_FFFF);
    send_record(ACT_LOAD, 32'hFFFF_FFFF);
    send_record(ACT_MODIFY, 32'hFFFF_FFFF);
    send_record(ACT_STORE, 32'hFFFF_FFF0);
    send_record(ACT_MODIFY, 32'h0000_0000);
    send_record(ACT_INSTR, 32'h0000_0000);
    send_record(ACT_LOAD, 32'h8000_0000);
    send_record(ACT_STORE, 32'h7FFF_FFFF);
    wait_drain();
  endtask

  // Two ways, one set bit: the least recently used line must be the one replaced.
  task automatic test_lru_order();
    configure(1, 2, 4);
    send_record(ACT_LOAD, 32'h0000_0000);
    send_record(ACT_LOAD, 32'h0000_0020);
    send_record(ACT_LOAD, 32'h0000_0000);
    send_record(ACT_LOAD, 32'h0000_0040);
    send_record(ACT_LOAD, 32'h0000_0020);
    send_record(ACT_MODIFY, 32'h0000_0000);
    wait_drain();
  endtask

  task automatic test_small_sets();         run_trace(2, 4, 4, 75);   endtask
  task automatic test_set_bits_saturation(); run_trace(7, 8, 5, 75);  endtask
  task automatic test_single_set();         run_trace(0, 0, 0, 75);   endtask
  task automatic test_wide_offset();        run_trace(1, 15, 31, 75); endtask
  task automatic test_deep_tag_shift();     run_trace(6, 3, 25, 75);  endtask
  task automatic test_full_ways();          run_trace(3, 8, 1, 75);   endtask
  task automatic test_two_ways();           run_trace(4, 2, 20, 75);  endtask
  task automatic test_odd_ways();           run_trace(5, 5, 2, 75);   endtask

  // The receiver holds off long enough that the result stays pending and the
  // block stops taking requests while the sender keeps offering.
  task automatic test_output_backpressure();
    configure(2, 2, 3);
    @(posedge clk);
    recv_hold_cycles = 300;
    for (int i = 0; i < 30; i++) begin
      send_record(action_t'($urandom_range(3)),
                  make_addr($urandom_range(3), $urandom_range(3)));
    end
    wait_drain();
  endtask

  always @(negedge clk) begin
    if (recv_hold_cycles > 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    record_result_t got;
    record_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.outcome = m_axis_tdata[OUT_OUTCOME_LSB +: 2];
      got.second_hit = m_axis_tdata[OUT_SECOND_LSB];
      got.hits = m_axis_tdata[OUT_HITS_LSB +: TOTAL_W];
      got.misses = m_axis_tdata[OUT_MISSES_LSB +: TOTAL_W];
      got.evictions = m_axis_tdata[OUT_EVICTS_LSB +: TOTAL_W];
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
      end else begin
        want = expected_results.pop_front();
        if (got.outcome !== want.outcome || got.second_hit !== want.second_hit ||
            got.hits !== want.hits || got.misses !== want.misses ||
            got.evictions !== want.evictions) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"%0t: mismatch outcome %0d/%0d second %0d/%0d hits %0d/%0d",
                      " misses %0d/%0d evictions %0d/%0d (exp/got)"},
                     $realtime, want.outcome, got.outcome, want.second_hit, got.second_hit,
                     want.hits, got.hits, want.misses, got.misses,
                     want.evictions, got.evictions);
        end
      end
    end
  end

  initial begin
    foreach (way_valid[i]) way_valid[i] = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 34;
    recv_idle_pct = 74;
    test_reset_geometry();
    test_lru_order();
    test_small_sets();
    test_set_bits_saturation();
    test_single_set();

    send_idle_pct = 74;
    recv_idle_pct = 34;
    test_wide_offset();
    test_deep_tag_shift();
    test_full_ways();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_two_ways();
    test_odd_ways();
    test_output_backpressure();

    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("lru_set_assoc_cache_sim_tb: done, clean");
    end else begin
      $display("lru_set_assoc_cache_sim_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("lru_set_assoc_cache_sim_tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/lsac_pkg.sv
sv/lsac_line_mem.sv
sv/lsac_way_scan.sv
sv/lru_set_assoc_cache_sim.sv
sv/lsac_checker.sv
bench/lru_set_assoc_cache_sim_tb.sv
